// File: design/u16u8_pkg.sv
// ----------------------------------------------------------------------------
// u16u8_pkg
// shared types, constants and the code point encoder for the utf-16 to utf-8
// transcoder
// ----------------------------------------------------------------------------
package u16u8_pkg;

	localparam int unsigned UNIT_W      = 16;
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned CP_W        = 21;
	localparam int unsigned SURR_W      = 10;
	localparam int unsigned MAX_BYTES   = 6;
	localparam int unsigned CNT_W       = 3;

	// upper six bits of a surrogate unit
	localparam logic [5:0] HIGH_TAG = 6'h36;
	localparam logic [5:0] LOW_TAG  = 6'h37;

	localparam logic [CP_W-1:0] ONE_BYTE_LIMIT   = 21'h00080;
	localparam logic [CP_W-1:0] TWO_BYTE_LIMIT   = 21'h00800;
	localparam logic [CP_W-1:0] THREE_BYTE_LIMIT = 21'h10000;
	localparam logic [CP_W-1:0] SUPP_OFFSET      = 21'h10000;

	localparam logic [BYTE_W-1:0] LEAD2 = 8'hC0;
	localparam logic [BYTE_W-1:0] LEAD3 = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD4 = 8'hF0;
	localparam logic [BYTE_W-1:0] CONT  = 8'h80;

	typedef struct packed {
		logic [3:0][BYTE_W-1:0] bytes;
		logic [CNT_W-1:0]       len;
	} enc_t;

	// one queued request: the bytes caused by one input unit, first in index 0
	typedef struct packed {
		logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
		logic [CNT_W-1:0]                 count;
	} entry_t;

	function automatic enc_t encode_point(input logic [CP_W-1:0] cp);
		enc_t e;
		e.bytes = '0;
		e.len   = '0;
		if (cp < ONE_BYTE_LIMIT) begin
			e.bytes[0] = cp[7:0];
			e.len      = 3'd1;
		end else if (cp < TWO_BYTE_LIMIT) begin
			e.bytes[0] = LEAD2 | {3'b000, cp[10:6]};
			e.bytes[1] = CONT | {2'b00, cp[5:0]};
			e.len      = 3'd2;
		end else if (cp < THREE_BYTE_LIMIT) begin
			e.bytes[0] = LEAD3 | {4'b0000, cp[15:12]};
			e.bytes[1] = CONT | {2'b00, cp[11:6]};
			e.bytes[2] = CONT | {2'b00, cp[5:0]};
			e.len      = 3'd3;
		end else begin
			e.bytes[0] = LEAD4 | {5'b00000, cp[20:18]};
			e.bytes[1] = CONT | {2'b00, cp[17:12]};
			e.bytes[2] = CONT | {2'b00, cp[11:6]};
			e.bytes[3] = CONT | {2'b00, cp[5:0]};
			e.len      = 3'd4;
		end
		return e;
	endfunction

endpackage

// File: design/u16u8_front.sv
// ----------------------------------------------------------------------------
// u16u8_front
// takes utf-16 units, pairs surrogates and encodes each request into a
// queue entry of up to six utf-8 bytes
// ----------------------------------------------------------------------------
module u16u8_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [15:0]           s_tdata,   // code_unit
	input  logic                  s_tlast,   // last_unit
	input  logic                  q_full,
	output logic                  push,
	output u16u8_pkg::entry_t     push_entry
);
	import u16u8_pkg::*;

	logic              held_q;
	logic [SURR_W-1:0] held_bits_q;
	logic              is_high;
	logic              is_low;
	logic              accept;
	logic              hold_new;
	enc_t              enc_pair;
	enc_t              enc_held;
	enc_t              enc_unit;
	entry_t            ent;

	assign is_high  = (s_tdata[15:10] == HIGH_TAG);
	assign is_low   = (s_tdata[15:10] == LOW_TAG);
	assign s_tready = !q_full;
	assign accept   = s_tvalid && !q_full;
	assign hold_new = is_high && !s_tlast;

	assign enc_pair = encode_point(SUPP_OFFSET + {1'b0, held_bits_q, s_tdata[9:0]});
	assign enc_held = encode_point({5'b00000, HIGH_TAG, held_bits_q});
	assign enc_unit = encode_point({5'b00000, s_tdata});

	always_comb begin
		ent = '0;
		if (held_q && is_low) begin
			ent.bytes[3:0] = enc_pair.bytes;
			ent.count      = enc_pair.len;
		end else if (held_q) begin
			// lone high surrogate goes first, then the new unit unless it is held
			ent.bytes[2:0] = enc_held.bytes[2:0];
			ent.count      = 3'd3;
			if (!hold_new) begin
				ent.bytes[5:3] = enc_unit.bytes[2:0];
				ent.count      = 3'd3 + enc_unit.len;
			end
		end else if (!hold_new) begin
			ent.bytes[2:0] = enc_unit.bytes[2:0];
			ent.count      = enc_unit.len;
		end
	end

	assign push       = accept && (ent.count != '0);
	assign push_entry = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= 1'b0;
			held_bits_q <= '0;
		end else if (accept) begin
			if (held_q && is_low) begin
				held_q      <= 1'b0;
				held_bits_q <= '0;
			end else if (hold_new) begin
				held_q      <= 1'b1;
				held_bits_q <= s_tdata[9:0];
			end else begin
				held_q      <= 1'b0;
				held_bits_q <= '0;
			end
		end
	end

endmodule

// File: design/u16u8_queue.sv
// ----------------------------------------------------------------------------
// u16u8_queue
// small fifo of encoded requests between the front and the back
// ----------------------------------------------------------------------------
module u16u8_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  u16u8_pkg::entry_t push_entry,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output u16u8_pkg::entry_t head_entry
);
	import u16u8_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	entry_t          store_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: design/u16u8_back.sv
// ----------------------------------------------------------------------------
// u16u8_back
// walks the bytes of the head entry into a registered byte-wide output
// ----------------------------------------------------------------------------
module u16u8_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  u16u8_pkg::entry_t head_entry,
	output logic              pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,   // utf8_byte
	output logic              m_tlast    // last_of_run
);
	import u16u8_pkg::*;

	logic [CNT_W-1:0]  idx_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_last_q;
	logic              load;
	logic              final_byte;

	assign load       = head_valid && (!out_valid_q || m_tready);
	assign final_byte = (idx_q == head_entry.count - 3'd1);
	assign pop        = load && final_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= final_byte ? '0 : idx_q + 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= head_entry.bytes[idx_q];
			out_last_q <= final_byte;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;

endmodule

// File: design/utf16_to_utf8_transcoder_core.sv
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_core
// streaming utf-16 to utf-8 transcoder with surrogate pairing
// ----------------------------------------------------------------------------
// usage
//   s_* takes one utf-16 code unit per request, s_tlast marks the end of the
//   string. m_* gives one utf-8 byte per request, m_tlast marks the final
//   byte caused by an input unit.
//   a high surrogate not marked last is held back and gives no bytes until
//   the next unit arrives; a following low surrogate turns the pair into four
//   bytes, anything else first flushes the held surrogate as three bytes.
//   a unit that is taken is written to the queue, and its first byte then goes
//   through the output register onto m_tdata, if the queue was empty and the
//   output free.
//   throughput: one byte per cycle on the output while m_tready is high; a unit
//   gives one, two, three or four bytes (three to six when a held surrogate is
//   flushed, none while a surrogate is held); the output byte register sets the
//   rate. the front takes a unit every cycle while the request queue has room.
//   a stall on m_tready holds the byte in the output register; the queue
//   fills and s_tready drops once it is full.
//   reset empties the queue, clears the held surrogate and drops m_tvalid.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder_core #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // code_unit
	input  logic        s_tlast,   // last_unit
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // utf8_byte
	output logic        m_tlast    // last_of_run
);
	import u16u8_pkg::*;

	logic   push;
	entry_t push_entry;
	logic   q_full;
	logic   pop;
	logic   head_valid;
	entry_t head_entry;

	u16u8_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	u16u8_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	u16u8_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule
